/* rtl/core/ile_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the list engine.
`timescale 1ns / 1ps

package ile_pkg;

  localparam int CAPACITY_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int OPCODE_W   = 3;
  localparam int POSITION_W = 8;
  localparam int ITEM_W     = 32;
  localparam int RESULT_W   = 32;
  localparam int STATUS_W   = 2;

  localparam logic [OPCODE_W-1:0] OP_READ    = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_INS_HEAD = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_INS_TAIL = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_INS_POS  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_DELETE   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic set_bad;
    logic set_full;
    logic walk_start;
    logic walk_step;
    logic pop_take;
    logic no_walk;
    logic fetched;
    logic link_new;
    logic link_nbr;
    logic unlink;
    logic load_out;
  } ile_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_read;
    logic op_insert;
    logic op_delete;
    logic bad_pos;
    logic full;
    logic ins_walk;
    logic walk_done;
    logic out_free;
  } ile_sts_t;

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_DECODE    = 11'b000_0000_0010,
    S_ALLOC     = 11'b000_0000_0100,
    S_WALK      = 11'b000_0000_1000,
    S_WALK_STEP = 11'b000_0001_0000,
    S_FETCHED   = 11'b000_0010_0000,
    S_LINK_NEW  = 11'b000_0100_0000,
    S_LINK_NBR  = 11'b000_1000_0000,
    S_UNLINK    = 11'b001_0000_0000,
    S_RESULT    = 11'b010_0000_0000,
    S_SPARE     = 11'b100_0000_0000
  } ile_state_t;

endpackage

/* rtl/core/ile_ram.sv */
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module ile_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/ile_datapath.sv */
// Datapath of the list engine: link and value memories, free slot stack, walk and result registers.
`timescale 1ns / 1ps

module ile_datapath import ile_pkg::*; #(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ile_cmd_t                     cmd,
  output ile_sts_t                     sts,
  input  logic [OPCODE_W-1:0]          opcode,
  input  logic signed [POSITION_W-1:0] position,
  input  logic [ITEM_W-1:0]            item_value,
  input  logic                         m_ready,
  output logic                         m_valid,
  output logic [RESULT_W-1:0]          read_value,
  output logic [STATUS_W-1:0]          status
);

  localparam int SW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = ((LW > POSITION_W) ? LW : POSITION_W) + 1;
  localparam logic [LW-1:0]        NIL     = LW'(CAPACITY);
  localparam logic signed [CW-1:0] NEG_ONE = '1;

  logic [OPCODE_W-1:0]          op;
  logic signed [POSITION_W-1:0] pos;
  logic [ITEM_W-1:0]            item;

  logic [LW-1:0] first_slot, last_slot, length, fresh, stack_cnt;
  logic [LW-1:0] cur, cnt, prev_slot, next_slot;
  logic [SW-1:0] new_slot;
  logic [RESULT_W-1:0] res_value;
  logic [STATUS_W-1:0] res_status;

  logic [VALUE_WIDTH-1:0] val_rdata;
  logic [LW-1:0]          fwd_rdata, bwd_rdata;
  logic [SW-1:0]          stk_rdata;

  logic                   fwd_we, bwd_we, val_we, stk_we;
  logic [SW-1:0]          fwd_waddr, bwd_waddr;
  logic [LW-1:0]          fwd_wdata, bwd_wdata;
  logic signed [CW-1:0]   pos_x, len_x;
  logic                   in_list, prev_is_slot, next_is_slot;
  logic [LW-1:0]          tgt;
  logic signed [VALUE_WIDTH-1:0] val_signed;

  assign pos_x   = CW'(pos);
  assign len_x   = CW'(length);
  assign in_list = (pos_x >= 0) && (pos_x < len_x);

  assign prev_is_slot = prev_slot < NIL;
  assign next_is_slot = next_slot < NIL;

  always_comb begin
    sts.op_read   = (op == OP_READ);
    sts.op_insert = (op == OP_INS_HEAD) || (op == OP_INS_TAIL) || (op == OP_INS_POS);
    sts.op_delete = (op == OP_DELETE);
    case (op)
      OP_READ, OP_DELETE: sts.bad_pos = !in_list;
      OP_INS_POS:         sts.bad_pos = (pos_x < NEG_ONE) || (pos_x > len_x);
      default:            sts.bad_pos = 1'b0;
    endcase
    case (op)
      OP_INS_HEAD: tgt = '0;
      OP_INS_TAIL: tgt = length;
      OP_INS_POS:  tgt = (pos_x < 0) ? '0 : LW'(pos_x);
      default:     tgt = LW'(pos_x);
    endcase
    sts.full      = (stack_cnt == '0) && (fresh == NIL);
    sts.ins_walk  = tgt < length;
    sts.walk_done = cnt == tgt;
    sts.out_free  = !m_valid || m_ready;
  end

  // Link memory write steering: a new node's own links first, then its neighbours.
  always_comb begin
    val_we    = cmd.link_new;
    fwd_we    = cmd.link_new || ((cmd.link_nbr || cmd.unlink) && prev_is_slot);
    bwd_we    = cmd.link_new || ((cmd.link_nbr || cmd.unlink) && next_is_slot);
    fwd_waddr = cmd.link_new ? new_slot : SW'(prev_slot);
    bwd_waddr = cmd.link_new ? new_slot : SW'(next_slot);
    if (cmd.link_new) begin
      fwd_wdata = next_slot;
      bwd_wdata = prev_slot;
    end else if (cmd.link_nbr) begin
      fwd_wdata = LW'(new_slot);
      bwd_wdata = LW'(new_slot);
    end else begin
      fwd_wdata = next_slot;
      bwd_wdata = prev_slot;
    end
    stk_we = cmd.unlink;
  end

  ile_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (new_slot),
    .wdata (VALUE_WIDTH'(item)),
    .raddr (SW'(cur)),
    .rdata (val_rdata)
  );

  ile_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_fwd_ram (
    .clk   (clk),
    .we    (fwd_we),
    .waddr (fwd_waddr),
    .wdata (fwd_wdata),
    .raddr (SW'(cur)),
    .rdata (fwd_rdata)
  );

  ile_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_bwd_ram (
    .clk   (clk),
    .we    (bwd_we),
    .waddr (bwd_waddr),
    .wdata (bwd_wdata),
    .raddr (SW'(cur)),
    .rdata (bwd_rdata)
  );

  // Stack of released slots; slots never used yet come from the fresh counter instead.
  ile_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (SW'(stack_cnt)),
    .wdata (SW'(cur)),
    .raddr (SW'(stack_cnt - LW'(1))),
    .rdata (stk_rdata)
  );

  assign val_signed = val_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_slot <= NIL;
      last_slot  <= NIL;
      length     <= '0;
      fresh      <= '0;
      stack_cnt  <= '0;
      m_valid    <= 1'b0;
    end else begin
      if (cmd.pop_take) begin
        if (stack_cnt == '0) begin
          fresh <= fresh + LW'(1);
        end else begin
          stack_cnt <= stack_cnt - LW'(1);
        end
      end
      if (cmd.link_nbr) begin
        if (!prev_is_slot) begin
          first_slot <= LW'(new_slot);
        end
        if (!next_is_slot) begin
          last_slot <= LW'(new_slot);
        end
        length <= length + LW'(1);
      end
      if (cmd.unlink) begin
        if (!prev_is_slot) begin
          first_slot <= next_slot;
        end
        if (!next_is_slot) begin
          last_slot <= prev_slot;
        end
        length    <= length - LW'(1);
        stack_cnt <= stack_cnt + LW'(1);
      end
      if (cmd.load_out) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op         <= opcode;
      pos        <= position;
      item       <= item_value;
      res_value  <= '0;
      res_status <= ST_DONE;
    end
    if (cmd.set_bad) begin
      res_status <= ST_BAD_POS;
      res_value  <= sts.op_read ? '1 : '0;
    end
    if (cmd.set_full) begin
      res_status <= ST_FULL;
    end
    if (cmd.pop_take) begin
      new_slot <= (stack_cnt == '0) ? SW'(fresh) : stk_rdata;
    end
    if (cmd.walk_start) begin
      cur <= first_slot;
      cnt <= '0;
    end
    if (cmd.walk_step) begin
      cur <= fwd_rdata;
      cnt <= cnt + LW'(1);
    end
    if (cmd.no_walk) begin
      next_slot <= NIL;
      prev_slot <= last_slot;
    end
    if (cmd.fetched) begin
      prev_slot <= bwd_rdata;
      next_slot <= sts.op_delete ? fwd_rdata : cur;
      if (sts.op_read) begin
        res_value <= RESULT_W'(64'(val_signed));
      end
    end
    if (cmd.load_out) begin
      read_value <= res_value;
      status     <= res_status;
    end
  end

endmodule

/* rtl/core/ile_ctrl.sv */
// Controller state machine of the list engine: sequences decode, allocation, walk and relinking.
`timescale 1ns / 1ps

module ile_ctrl import ile_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_valid,
  output logic     s_ready,
  input  ile_sts_t sts,
  output ile_cmd_t cmd
);

  ile_state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_ready    = 1'b0;
    case (state)
      S_IDLE: begin
        s_ready    = 1'b1;
        cmd.accept = s_valid;
        if (s_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.op_read || sts.op_delete) begin
          if (sts.bad_pos) begin
            cmd.set_bad = 1'b1;
            state_next  = S_RESULT;
          end else begin
            cmd.walk_start = 1'b1;
            state_next     = S_WALK;
          end
        end else if (sts.op_insert) begin
          if (sts.bad_pos) begin
            cmd.set_bad = 1'b1;
            state_next  = S_RESULT;
          end else if (sts.full) begin
            cmd.set_full = 1'b1;
            state_next   = S_RESULT;
          end else begin
            state_next = S_ALLOC;
          end
        end else begin
          state_next = S_RESULT;
        end
      end
      S_ALLOC: begin
        cmd.pop_take = 1'b1;
        if (sts.ins_walk) begin
          cmd.walk_start = 1'b1;
          state_next     = S_WALK;
        end else begin
          cmd.no_walk = 1'b1;
          state_next  = S_LINK_NEW;
        end
      end
      S_WALK: begin
        state_next = sts.walk_done ? S_FETCHED : S_WALK_STEP;
      end
      S_WALK_STEP: begin
        cmd.walk_step = 1'b1;
        state_next    = S_WALK;
      end
      S_FETCHED: begin
        cmd.fetched = 1'b1;
        if (sts.op_read) begin
          state_next = S_RESULT;
        end else if (sts.op_insert) begin
          state_next = S_LINK_NEW;
        end else begin
          state_next = S_UNLINK;
        end
      end
      S_LINK_NEW: begin
        cmd.link_new = 1'b1;
        state_next   = S_LINK_NBR;
      end
      S_LINK_NBR: begin
        cmd.link_nbr = 1'b1;
        state_next   = S_RESULT;
      end
      S_UNLINK: begin
        cmd.unlink = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/core/indexed_list_engine.sv */
// Top level of the indexed list engine: a doubly linked list of values in a slot memory.
//
//  channel  | dir | tdata fields (low bit up)                      | tuser/tlast
//  s_axis   | in  | opcode[2:0] position[10:3] item_value[42:11]   | none
//  m_axis   | out | read_value[31:0] status[33:32]                 | none
//
// A read, a delete and a walking insert walk from the head to the list position, each
// forward link taking a registered read and then a cursor move; a tail insert and a
// refused request do not walk.
// Reset is synchronous; the slot memories need no clearing pass, so a request is taken
// in the cycle after reset. The result waits in an output register, and the next request
// is taken while it is still stalled on the master side.
`timescale 1ns / 1ps

module indexed_list_engine import ile_pkg::*; #(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // opcode, position, item_value, zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // read_value, status, zero pad
);

  ile_cmd_t cmd;
  ile_sts_t sts;
  logic [RESULT_W-1:0] read_value;
  logic [STATUS_W-1:0] status;

  ile_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .s_ready (s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  ile_datapath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .opcode     (s_tdata[2:0]),
    .position   (s_tdata[10:3]),
    .item_value (s_tdata[42:11]),
    .m_ready    (m_tready),
    .m_valid    (m_tvalid),
    .read_value (read_value),
    .status     (status)
  );

  assign m_tdata = {6'b0, status, read_value};

endmodule

/* rtl/core/ile_checker.sv */
// Port-level checks on the list engine, bound to the top level.
`timescale 1ns / 1ps

module ile_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // A stalled result transfer keeps its data.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // One request at a time: after an input transfer the slave side closes.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while another is in progress");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[33:32] != 2'd3)
    else $error("unknown status code");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[39:34] == 6'd0)
    else $error("padding bits of result not zero");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result presented straight after reset");

endmodule

bind indexed_list_engine ile_checker u_ile_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* tb/tb_top.sv */
// Self-checking testbench for the indexed list engine: list operations against a queue model.
`timescale 1ns / 1ps

module tb_top;
  import ile_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 2 * CAPACITY_DEF + 12;

  typedef struct packed {
    logic [RESULT_W-1:0] read_value;
    logic [STATUS_W-1:0] status;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // opcode, position, item_value, zero pad
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // read_value, status, zero pad

  // Values in list order, head first; the store is full when it holds CAPACITY_DEF.
  logic [ITEM_W-1:0] list_contents[$];
  reply_t            pending_replies[$];
  int                error_count = 0;
  int                cycle_count = 0;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;

  indexed_list_engine i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    error_count++;
  endtask

  // Applies one request to the list model and returns the reply it should give.
  function automatic reply_t list_apply(input logic [OPCODE_W-1:0] op,
                                        input logic signed [POSITION_W-1:0] pos,
                                        input logic [ITEM_W-1:0] val);
    reply_t rep;
    int     p;
    int     len;
    rep.read_value = '0;
    rep.status     = ST_DONE;
    p   = int'(pos);
    len = list_contents.size();
    case (op)
      OP_READ: begin
        if (p >= 0 && p < len) begin
          rep.read_value = list_contents[p];
        end else begin
          rep.read_value = '1;
          rep.status     = ST_BAD_POS;
        end
      end
      OP_INS_HEAD: begin
        if (len >= CAPACITY_DEF) rep.status = ST_FULL;
        else list_contents.push_front(val);
      end
      OP_INS_TAIL: begin
        if (len >= CAPACITY_DEF) rep.status = ST_FULL;
        else list_contents.push_back(val);
      end
      OP_INS_POS: begin
        // The position is judged before the free store.
        if (p < -1 || p > len) rep.status = ST_BAD_POS;
        else if (len >= CAPACITY_DEF) rep.status = ST_FULL;
        else if (p == len) list_contents.push_back(val);
        else list_contents.insert((p < 0) ? 0 : p, val);
      end
      OP_DELETE: begin
        if (p >= 0 && p < len) list_contents.delete(p);
        else rep.status = ST_BAD_POS;
      end
      default: ;
    endcase
    return rep;
  endfunction

  task automatic send_request(input logic [OPCODE_W-1:0] op,
                              input logic signed [POSITION_W-1:0] pos,
                              input logic [ITEM_W-1:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, val, pos, op};
    do @(posedge clk); while (!s_tready);
    pending_replies.push_back(list_apply(op, pos, val));
  endtask

  // Result side: random back-pressure and a field-by-field compare on every transfer.
  always @(posedge clk) begin
    reply_t want;
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    if (!rst && m_tvalid && m_tready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding, tdata %h", m_tdata));
      end else begin
        want = pending_replies.pop_front();
        if (m_tdata[31:0] !== want.read_value)
          report_mismatch($sformatf("read_value %h, expected %h", m_tdata[31:0],
                                    want.read_value));
        if (m_tdata[33:32] !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", m_tdata[33:32],
                                    want.status));
      end
    end
  end

  // Bad-position cases for read, delete and positional insert on an empty list, and the unused opcodes.
  task automatic test_empty_list();
    send_request(OP_READ,   8'sd0,    32'h0000_0000);
    send_request(OP_READ,   -8'sd1,   32'hffff_ffff);
    send_request(OP_READ,   -8'sd128, 32'h1234_5678);
    send_request(OP_READ,   8'sd127,  32'h0);
    send_request(OP_DELETE, 8'sd0,    32'h0);
    send_request(OP_DELETE, -8'sd128, 32'h0);
    send_request(OP_INS_POS, 8'sd1,   32'hdead_beef);
    send_request(OP_INS_POS, -8'sd2,  32'hdead_beef);
    send_request(OP_INS_POS, -8'sd128, 32'hdead_beef);
    send_request(3'd5, 8'sd0, 32'hffff_ffff);
    send_request(3'd6, 8'sd3, 32'h0);
    send_request(3'd7, -8'sd1, 32'h8000_0000);
  endtask

  // Each way of inserting and deleting, with the value extremes, read back.
  task automatic test_edit_and_read();
    send_request(OP_INS_HEAD, 8'sd0,  32'h8000_0000);
    send_request(OP_INS_TAIL, 8'sd0,  32'h7fff_ffff);
    send_request(OP_INS_POS,  -8'sd1, 32'h0000_0000);
    send_request(OP_INS_POS,  8'sd3,  32'hffff_ffff);
    send_request(OP_INS_POS,  8'sd1,  32'h5555_5555);
    for (int k = 0; k < 5; k++) send_request(OP_READ, k[7:0], 32'haaaa_aaaa);
    send_request(OP_READ,   8'sd5, 32'h0);
    send_request(OP_DELETE, 8'sd2, 32'h0);
    send_request(OP_DELETE, 8'sd3, 32'h0);
    send_request(OP_DELETE, 8'sd0, 32'h0);
    send_request(OP_DELETE, 8'sd5, 32'h0);
    send_request(OP_READ,   8'sd1, 32'h0);
  endtask

  function automatic logic [ITEM_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // Random traffic in episodes that grow, shrink or churn the list, so that a full
  // store and an empty list are both reached repeatedly.
  task automatic test_random_traffic(input int count);
    int ins_pct;
    int del_pct;
    int left_in_episode;
    int len;
    int r;
    logic [OPCODE_W-1:0]          op;
    logic signed [POSITION_W-1:0] pos;
    left_in_episode = 0;
    ins_pct = 45;
    del_pct = 25;
    for (int n = 0; n < count; n++) begin
      if (left_in_episode == 0) begin
        left_in_episode = $urandom_range(40, 160);
        case ($urandom_range(0, 2))
          0: begin ins_pct = 75; del_pct = 10; end
          1: begin ins_pct = 20; del_pct = 60; end
          default: begin ins_pct = 45; del_pct = 25; end
        endcase
      end
      left_in_episode--;
      len = list_contents.size();
      r   = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 10) begin
        op  = OPCODE_W'($urandom_range(0, 7));
        pos = POSITION_W'($urandom());
      end else if (r < ins_pct) begin
        case ($urandom_range(0, 2))
          0: op = OP_INS_HEAD;
          1: op = OP_INS_TAIL;
          default: op = OP_INS_POS;
        endcase
        if ($urandom_range(0, 19) == 0) pos = POSITION_W'(len + 1);
        else pos = POSITION_W'(int'($urandom_range(0, len + 1)) - 1);
      end else begin
        op = (r < ins_pct + del_pct) ? OP_DELETE : OP_READ;
        if (len == 0 || $urandom_range(0, 19) == 0)
          pos = POSITION_W'(($urandom_range(0, 1)) ? len : -1);
        else pos = POSITION_W'($urandom_range(0, len - 1));
      end
      send_request(op, pos, pick_value());
    end
  endtask

  initial begin
    send_idle_pct = 14;
    recv_idle_pct = 68;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_edit_and_read();
    test_random_traffic(570);
    send_idle_pct = 68;
    recv_idle_pct = 14;
    test_random_traffic(570);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(570);
    s_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/ile_pkg.sv
rtl/core/ile_ram.sv
rtl/core/ile_datapath.sv
rtl/core/ile_ctrl.sv
rtl/core/indexed_list_engine.sv
rtl/core/ile_checker.sv
tb/tb_top.sv
